// ===== hw/rtl/cyclic_voltammetry_sweep_macros.svh =====
// Assertion macros shared by the sweep sequencer RTL.
// Needs nothing else; included by files that carry concurrent assertions.
`ifndef CYCLIC_VOLTAMMETRY_SWEEP_MACROS_SVH
`define CYCLIC_VOLTAMMETRY_SWEEP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CVS_ASSERT_SAME(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("sweep sequencer check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define CVS_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("sweep sequencer check failed");

`endif

// ===== hw/rtl/cvs_pkg.sv =====
// Shared types and constants of the cyclic voltammetry sweep sequencer.
// No dependencies; used by all modules.
`timescale 1ns / 1ps
`default_nettype none

package cvs_pkg;

   // Byte address width of the register port: six registers at 4-byte spacing.
   localparam int unsigned CSR_ADDR_W = 5;

   // Input operation codes.
   typedef enum logic {
      OP_START = 1'b0,
      OP_TICK  = 1'b1
   } op_type;

   // Register indexes, the word address of the register port.
   typedef enum logic [2:0] {
      REG_BEGIN_VOLTAGE    = 3'd0,
      REG_FIRST_VERTEX     = 3'd1,
      REG_SECOND_VERTEX    = 3'd2,
      REG_STEP_SIZE        = 3'd3,
      REG_CYCLE_COUNT      = 3'd4,
      REG_SAMPLE_PERIOD_MS = 3'd5
   } reg_index_type;

   // Sweep segment, one-hot.
   typedef enum logic [2:0] {
      SEG_RISE_V1    = 3'b001,
      SEG_FALL_V2    = 3'b010,
      SEG_RISE_BEGIN = 3'b100
   } seg_type;

   // Configuration register contents.
   typedef struct packed {
      logic signed [15:0] begin_voltage;
      logic signed [15:0] first_vertex;
      logic signed [15:0] second_vertex;
      logic [14:0]        step_size;
      logic [7:0]         cycle_count;
      logic [15:0]        sample_period_ms;
   } cfg_type;

   // Sweep state.
   typedef struct packed {
      logic signed [15:0] setpoint;
      seg_type            segment;
      logic [7:0]         cycles_left;
      logic [31:0]        point_counter;
      logic [31:0]        time_counter;
      logic               running;
   } state_type;

   // One result record.
   typedef struct packed {
      logic [31:0]        point_index;
      logic [31:0]        elapsed_ms;
      logic [11:0]        measured_voltage;
      logic [11:0]        measured_current;
      logic signed [15:0] drive_setpoint;
      logic               last_point;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/cvs_channels.sv =====
// Valid/ready channel interfaces for the sweep sequencer's request and result beats.
// Depends on nothing but plain logic types.
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one beat is a start or a sample tick with two ADC codes.
interface cvs_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [11:0] voltage_code;
   logic [11:0] current_code;

   modport source (output valid, output operation, output voltage_code,
                   output current_code, input ready);
   modport sink   (input valid, input operation, input voltage_code,
                   input current_code, output ready);
endinterface

// Result channel: one beat is one measurement point record.
interface cvs_rsp_if;
   logic               valid;
   logic               ready;
   logic [31:0]        point_index;
   logic [31:0]        elapsed_ms;
   logic [11:0]        measured_voltage;
   logic [11:0]        measured_current;
   logic signed [15:0] drive_setpoint;
   logic               last_point;

   modport source (output valid, output point_index, output elapsed_ms,
                   output measured_voltage, output measured_current,
                   output drive_setpoint, output last_point, input ready);
   modport sink   (input valid, input point_index, input elapsed_ms,
                   input measured_voltage, input measured_current,
                   input drive_setpoint, input last_point, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cvs_csr.sv =====
// APB-style configuration register file of the sweep sequencer.
// Depends on cvs_pkg for the register layout and indexes.
`timescale 1ns / 1ps
`default_nettype none

module cvs_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [cvs_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                    pwdata,
   output logic      [31:0]                    prdata,
   output logic                                pready,
   output cvs_pkg::cfg_type                    cfg
);

   cvs_pkg::cfg_type      cfg_ff;
   cvs_pkg::cfg_type      cfg_in;
   cvs_pkg::reg_index_type reg_index;
   logic                  wr_en;

   assign pready    = 1'b1;
   assign reg_index = cvs_pkg::reg_index_type'(paddr[cvs_pkg::CSR_ADDR_W-1:2]);
   assign wr_en     = psel && penable && pwrite;
   assign cfg       = cfg_ff;

   // Write decode: a write to an unused address is dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            cvs_pkg::REG_BEGIN_VOLTAGE:    cfg_in.begin_voltage    = pwdata[15:0];
            cvs_pkg::REG_FIRST_VERTEX:     cfg_in.first_vertex     = pwdata[15:0];
            cvs_pkg::REG_SECOND_VERTEX:    cfg_in.second_vertex    = pwdata[15:0];
            cvs_pkg::REG_STEP_SIZE:        cfg_in.step_size        = pwdata[14:0];
            cvs_pkg::REG_CYCLE_COUNT:      cfg_in.cycle_count      = pwdata[7:0];
            cvs_pkg::REG_SAMPLE_PERIOD_MS: cfg_in.sample_period_ms = pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Register bank with its documented reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.begin_voltage    <= 16'sd0;
         cfg_ff.first_vertex     <= 16'sd0;
         cfg_ff.second_vertex    <= 16'sd0;
         cfg_ff.step_size        <= 15'd1;
         cfg_ff.cycle_count      <= 8'd1;
         cfg_ff.sample_period_ms <= 16'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read decode, zero-extended to the bus width.
   always_comb begin
      unique case (reg_index)
         cvs_pkg::REG_BEGIN_VOLTAGE:    prdata = {16'd0, cfg_ff.begin_voltage};
         cvs_pkg::REG_FIRST_VERTEX:     prdata = {16'd0, cfg_ff.first_vertex};
         cvs_pkg::REG_SECOND_VERTEX:    prdata = {16'd0, cfg_ff.second_vertex};
         cvs_pkg::REG_STEP_SIZE:        prdata = {17'd0, cfg_ff.step_size};
         cvs_pkg::REG_CYCLE_COUNT:      prdata = {24'd0, cfg_ff.cycle_count};
         cvs_pkg::REG_SAMPLE_PERIOD_MS: prdata = {16'd0, cfg_ff.sample_period_ms};
         default:                       prdata = 32'd0;
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/cvs_step.sv =====
// Next-state and result logic for one request beat of the sweep sequencer.
// Depends on cvs_pkg for the state, configuration and result types.
`timescale 1ns / 1ps
`default_nettype none

module cvs_step (
   input  wire cvs_pkg::cfg_type    cfg,
   input  wire cvs_pkg::state_type  st,
   input  wire logic                operation,
   input  wire logic [11:0]         voltage_code,
   input  wire logic [11:0]         current_code,
   output cvs_pkg::state_type       st_in,
   output logic                     produce,
   output cvs_pkg::result_type      result
);

   logic signed [15:0] target;
   logic [14:0]        step;
   logic signed [16:0] sp_wide;
   logic signed [16:0] tg_wide;
   logic signed [16:0] step_wide;
   logic signed [16:0] sp_up;
   logic signed [16:0] sp_down;
   logic [7:0]         cycles_dec;
   logic               at_target;
   logic               last;

   // Target of the current segment; an unknown code aims at the first vertex.
   always_comb begin
      unique case (st.segment)
         cvs_pkg::SEG_FALL_V2:    target = cfg.second_vertex;
         cvs_pkg::SEG_RISE_BEGIN: target = cfg.begin_voltage;
         default:                 target = cfg.first_vertex;
      endcase
   end

   // One step either way, kept one bit wider so the clamp compare is exact.
   assign step       = (cfg.step_size == 15'd0) ? 15'd1 : cfg.step_size;
   assign sp_wide    = {st.setpoint[15], st.setpoint};
   assign tg_wide    = {target[15], target};
   assign step_wide  = {2'b00, step};
   assign sp_up      = sp_wide + step_wide;
   assign sp_down    = sp_wide - step_wide;
   assign at_target  = (st.setpoint == target);
   assign cycles_dec = st.cycles_left - 8'd1;

   // State update and result flag.
   always_comb begin
      st_in   = st;
      produce = 1'b0;
      last    = 1'b0;
      if (operation == cvs_pkg::OP_START) begin
         st_in.setpoint      = cfg.begin_voltage;
         st_in.segment       = cvs_pkg::SEG_RISE_V1;
         st_in.point_counter = 32'd0;
         st_in.time_counter  = 32'd0;
         st_in.cycles_left   = cfg.cycle_count;
         st_in.running       = (cfg.cycle_count != 8'd0);
      end else if (st.running) begin
         produce             = 1'b1;
         st_in.point_counter = st.point_counter + 32'd1;
         st_in.time_counter  = st.time_counter + {16'd0, cfg.sample_period_ms};
         if (at_target) begin
            // Arrived: move on to the next segment.
            unique case (st.segment)
               cvs_pkg::SEG_FALL_V2: st_in.segment = cvs_pkg::SEG_RISE_BEGIN;
               cvs_pkg::SEG_RISE_BEGIN: begin
                  st_in.segment     = cvs_pkg::SEG_RISE_V1;
                  st_in.cycles_left = cycles_dec;
                  if (cycles_dec == 8'd0) begin
                     last          = 1'b1;
                     st_in.running = 1'b0;
                  end
               end
               default: st_in.segment = cvs_pkg::SEG_FALL_V2;
            endcase
         end else if (st.segment == cvs_pkg::SEG_FALL_V2) begin
            st_in.setpoint = (sp_down < tg_wide) ? target : sp_down[15:0];
         end else begin
            st_in.setpoint = (sp_up > tg_wide) ? target : sp_up[15:0];
         end
      end
   end

   // The record carries the point and time before they advance.
   assign result.point_index      = st.point_counter;
   assign result.elapsed_ms       = st.time_counter;
   assign result.measured_voltage = voltage_code;
   assign result.measured_current = current_code;
   assign result.drive_setpoint   = st_in.setpoint;
   assign result.last_point       = last;

endmodule

`default_nettype wire

// ===== hw/rtl/cyclic_voltammetry_sweep.sv =====
// Cyclic voltammetry triangle sweep sequencer: one request beat per clock; an
// accepted sample tick has its record in the result register in the next
// cycle. The whole update is a single add, compare and clamp on the 16-bit
// setpoint, so a new beat is taken every cycle; req.ready drops only while a
// record sits in the result register and the sink is not taking it. A start
// beat and a tick while idle give no record. Configuration registers are live
// except cycle_count, which is read at start.
// Depends on cvs_pkg, cvs_channels, cvs_csr, cvs_step and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "cyclic_voltammetry_sweep_macros.svh"

module cyclic_voltammetry_sweep (
   input  wire logic                           clock,
   input  wire logic                           reset,
   cvs_req_if.sink                             req_ch,
   cvs_rsp_if.source                           rsp_ch,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [cvs_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                    pwdata,
   output logic      [31:0]                    prdata,
   output logic                                pready
);

   cvs_pkg::cfg_type    cfg;
   cvs_pkg::state_type  st_ff;
   cvs_pkg::state_type  st_in;
   cvs_pkg::result_type result;
   cvs_pkg::result_type rsp_data_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                produce;
   logic                req_fire;

   // Register file.
   cvs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sweep update for the beat on the request channel.
   cvs_step u_step (
      .cfg          (cfg),
      .st           (st_ff),
      .operation    (req_ch.operation),
      .voltage_code (req_ch.voltage_code),
      .current_code (req_ch.current_code),
      .st_in        (st_in),
      .produce      (produce),
      .result       (result)
   );

   // Take a beat whenever the result register is free or being emptied.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = produce;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Sweep state.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.setpoint      <= 16'sd0;
         st_ff.segment       <= cvs_pkg::SEG_RISE_V1;
         st_ff.cycles_left   <= 8'd0;
         st_ff.point_counter <= 32'd0;
         st_ff.time_counter  <= 32'd0;
         st_ff.running       <= 1'b0;
      end else if (req_fire) begin
         st_ff <= st_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && produce) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.point_index      = rsp_data_ff.point_index;
   assign rsp_ch.elapsed_ms       = rsp_data_ff.elapsed_ms;
   assign rsp_ch.measured_voltage = rsp_data_ff.measured_voltage;
   assign rsp_ch.measured_current = rsp_data_ff.measured_current;
   assign rsp_ch.drive_setpoint   = rsp_data_ff.drive_setpoint;
   assign rsp_ch.last_point       = rsp_data_ff.last_point;

   // A held record must stall the request side.
   `CVS_ASSERT_SAME(a_stall_backpressure, clock, reset, rsp_valid_ff && !rsp_ch.ready, !req_ch.ready)
   // The final point of the last cycle leaves the sequencer idle.
   `CVS_ASSERT_NEXT(a_last_stops, clock, reset, req_fire && produce && result.last_point, !st_ff.running)
   // A beat that yields no record leaves the result register empty.
   `CVS_ASSERT_NEXT(a_no_spurious_rsp, clock, reset, req_fire && !produce, !rsp_valid_ff)

endmodule

`default_nettype wire

// ===== tb/cyclic_voltammetry_sweep_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the cyclic voltammetry sweep sequencer: a cycle-free
// predictor of the triangle sweep checks every result beat field by field.
// Depends on cvs_pkg, the cvs_channels interfaces and the sequencer RTL.

module cyclic_voltammetry_sweep_tb;

   localparam int unsigned ITEM_TARGET   = 700;
   localparam int unsigned QUIET_TAIL    = 100;
   localparam int unsigned SWEEP_TICKS   = 90;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned MAX_REPORTS   = 10;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [cvs_pkg::CSR_ADDR_W-1:0] paddr;
   logic [31:0]                    pwdata;
   logic [31:0]                    prdata;
   logic                           pready;

   cvs_req_if req_bus ();
   cvs_rsp_if rsp_bus ();

   cyclic_voltammetry_sweep DUT (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_bus),
      .rsp_ch  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Predicted registers and sweep state.
   cvs_pkg::cfg_type   sweep_cfg;
   logic signed [15:0] model_setpoint;
   cvs_pkg::seg_type   model_segment;
   logic [7:0]         model_cycles_left;
   logic [31:0]        model_points;
   logic [31:0]        model_time;
   logic               model_running;

   cvs_pkg::result_type expected_points[$];
   int unsigned         items_sent;
   int unsigned         mismatch_count;
   int unsigned         clock_cycles;
   int unsigned         stall_left;
   int unsigned         flow_left;
   bit                  quiet_tail;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      clock_cycles <= clock_cycles + 1;
      if (clock_cycles >= CYCLE_LIMIT) begin
         $display("cyclic_voltammetry_sweep: mismatch");
         $finish;
      end
   end

   // Applies one request beat to the predicted sweep; returns 1 when it yields a point.
   function automatic bit sweep_advance(input cvs_pkg::op_type op, input logic [11:0] vcode,
                                        input logic [11:0] icode,
                                        output cvs_pkg::result_type rec);
      int target;
      int stride;
      int next_sp;
      bit final_point;
      rec         = '0;
      final_point = 1'b0;
      if (op == cvs_pkg::OP_START) begin
         model_setpoint    = sweep_cfg.begin_voltage;
         model_segment     = cvs_pkg::SEG_RISE_V1;
         model_points      = '0;
         model_time        = '0;
         model_cycles_left = sweep_cfg.cycle_count;
         model_running     = (sweep_cfg.cycle_count != 8'd0);
         return 1'b0;
      end
      if (!model_running)
         return 1'b0;

      case (model_segment)
         cvs_pkg::SEG_FALL_V2:    target = int'($signed(sweep_cfg.second_vertex));
         cvs_pkg::SEG_RISE_BEGIN: target = int'($signed(sweep_cfg.begin_voltage));
         default:                 target = int'($signed(sweep_cfg.first_vertex));
      endcase

      // On target the segment turns; otherwise one clamped step toward it.
      if (int'(model_setpoint) == target) begin
         case (model_segment)
            cvs_pkg::SEG_FALL_V2: model_segment = cvs_pkg::SEG_RISE_BEGIN;
            cvs_pkg::SEG_RISE_BEGIN: begin
               model_segment     = cvs_pkg::SEG_RISE_V1;
               model_cycles_left = model_cycles_left - 8'd1;
               if (model_cycles_left == 8'd0) begin
                  final_point   = 1'b1;
                  model_running = 1'b0;
               end
            end
            default: model_segment = cvs_pkg::SEG_FALL_V2;
         endcase
      end else begin
         stride = (sweep_cfg.step_size == '0) ? 1 : int'(sweep_cfg.step_size);
         if (model_segment == cvs_pkg::SEG_FALL_V2) begin
            next_sp = int'(model_setpoint) - stride;
            if (next_sp < target)
               next_sp = target;
         end else begin
            next_sp = int'(model_setpoint) + stride;
            if (next_sp > target)
               next_sp = target;
         end
         model_setpoint = 16'(next_sp);
      end

      rec.point_index      = model_points;
      rec.elapsed_ms       = model_time;
      rec.measured_voltage = vcode;
      rec.measured_current = icode;
      rec.drive_setpoint   = model_setpoint;
      rec.last_point       = final_point;
      model_points         = model_points + 32'd1;
      model_time           = model_time + {16'd0, sweep_cfg.sample_period_ms};
      return 1'b1;
   endfunction

   function automatic logic [15:0] clamp16(input int v);
      if (v > 32767)
         return 16'h7FFF;
      if (v < -32768)
         return 16'h8000;
      return 16'(v);
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("point %0d: %s expected %0h, got %0h", rsp_bus.point_index, field, want, got);
   endtask

   // Result checker: every accepted beat is compared with the oldest expected point.
   always @(posedge clock) begin : point_checker
      cvs_pkg::result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_points.size() == 0) begin
            report_mismatch("unexpected beat, index", 32'd0, rsp_bus.point_index);
         end else begin
            want = expected_points.pop_front();
            if (rsp_bus.point_index !== want.point_index)
               report_mismatch("point_index", want.point_index, rsp_bus.point_index);
            if (rsp_bus.elapsed_ms !== want.elapsed_ms)
               report_mismatch("elapsed_ms", want.elapsed_ms, rsp_bus.elapsed_ms);
            if (rsp_bus.measured_voltage !== want.measured_voltage)
               report_mismatch("measured_voltage", want.measured_voltage,
                               rsp_bus.measured_voltage);
            if (rsp_bus.measured_current !== want.measured_current)
               report_mismatch("measured_current", want.measured_current,
                               rsp_bus.measured_current);
            if (rsp_bus.drive_setpoint !== want.drive_setpoint)
               report_mismatch("drive_setpoint", want.drive_setpoint, rsp_bus.drive_setpoint);
            if (rsp_bus.last_point !== want.last_point)
               report_mismatch("last_point", want.last_point, rsp_bus.last_point);
         end
      end
   end

   // Result sink: random stall bursts, stretches of steady flow, none in the tail.
   always @(posedge clock) begin
      if (reset || quiet_tail) begin
         rsp_bus.ready <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else if (flow_left != 0) begin
         rsp_bus.ready <= 1'b1;
         flow_left--;
      end else begin
         case ($urandom_range(0, 7))
            0: begin
               stall_left = $urandom_range(1, 18) - 1;
               rsp_bus.ready <= 1'b0;
            end
            1: begin
               flow_left = $urandom_range(10, 60);
               rsp_bus.ready <= 1'b1;
            end
            default: rsp_bus.ready <= 1'b1;
         endcase
      end
   end

   // Register write: setup and access phase, then psel drops back to idle.
   task automatic csr_write(input cvs_pkg::reg_index_type idx, input logic [15:0] field);
      logic [31:0] value;
      value = {16'($urandom), field};
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do
         @(posedge clock);
      while (!pready);
      case (idx)
         cvs_pkg::REG_BEGIN_VOLTAGE:    sweep_cfg.begin_voltage    = value[15:0];
         cvs_pkg::REG_FIRST_VERTEX:     sweep_cfg.first_vertex     = value[15:0];
         cvs_pkg::REG_SECOND_VERTEX:    sweep_cfg.second_vertex    = value[15:0];
         cvs_pkg::REG_STEP_SIZE:        sweep_cfg.step_size        = value[14:0];
         cvs_pkg::REG_CYCLE_COUNT:      sweep_cfg.cycle_count      = value[7:0];
         cvs_pkg::REG_SAMPLE_PERIOD_MS: sweep_cfg.sample_period_ms = value[15:0];
         default: ;
      endcase
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Sends one request beat, with an optional gap first, and records its prediction.
   task automatic send_item(input cvs_pkg::op_type op, input logic [11:0] vcode,
                            input logic [11:0] icode);
      cvs_pkg::result_type rec;
      bit                  counts;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.operation    <= op;
      req_bus.voltage_code <= vcode;
      req_bus.current_code <= icode;
      do
         @(posedge clock);
      while (!(req_bus.valid && req_bus.ready));
      counts = (op == cvs_pkg::OP_START) || model_running;
      if (sweep_advance(op, vcode, icode, rec))
         expected_points.push_back(rec);
      if (counts)
         items_sent++;
   endtask

   // Sends sample ticks while the predicted sweep runs, up to a cap.
   task automatic run_sweep(input int unsigned max_ticks, input bit full_scale_codes);
      int unsigned sent;
      sent = 0;
      while (model_running && sent < max_ticks) begin
         if (full_scale_codes)
            send_item(cvs_pkg::OP_TICK, sent[0] ? 12'hFFF : 12'h000,
                      sent[0] ? 12'h000 : 12'hFFF);
         else
            send_item(cvs_pkg::OP_TICK, 12'($urandom_range(0, 4095)),
                      12'($urandom_range(0, 4095)));
         sent++;
      end
   endtask

   // Lowers the request valid, waits for every expected point, then lets the block settle.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (expected_points.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Ticks before any start, and a start with a zero cycle count, give nothing.
   task automatic test_idle_ticks();
      send_item(cvs_pkg::OP_TICK, 12'hFFF, 12'h000);
      drain_results();
      csr_write(cvs_pkg::REG_CYCLE_COUNT, 16'd0);
      send_item(cvs_pkg::OP_START, 12'h000, 12'hFFF);
      send_item(cvs_pkg::OP_TICK, 12'h5A5, 12'hA5A);
      drain_results();
   endtask

   // Full-scale sweep with the largest step and period and extreme ADC codes.
   task automatic test_full_scale_sweep();
      csr_write(cvs_pkg::REG_BEGIN_VOLTAGE, 16'h8000);
      csr_write(cvs_pkg::REG_FIRST_VERTEX, 16'h7FFF);
      csr_write(cvs_pkg::REG_SECOND_VERTEX, 16'h8000);
      csr_write(cvs_pkg::REG_STEP_SIZE, 16'h7FFF);
      csr_write(cvs_pkg::REG_CYCLE_COUNT, 16'd1);
      csr_write(cvs_pkg::REG_SAMPLE_PERIOD_MS, 16'hFFFF);
      send_item(cvs_pkg::OP_START, 12'hFFF, 12'hFFF);
      run_sweep(16, 1'b1);
      drain_results();
   endtask

   // A zero step moves by one unit and a zero period freezes the time.
   task automatic test_zero_step_and_period();
      csr_write(cvs_pkg::REG_BEGIN_VOLTAGE, 16'd0);
      csr_write(cvs_pkg::REG_FIRST_VERTEX, 16'd1);
      csr_write(cvs_pkg::REG_SECOND_VERTEX, 16'd0);
      csr_write(cvs_pkg::REG_STEP_SIZE, 16'd0);
      csr_write(cvs_pkg::REG_SAMPLE_PERIOD_MS, 16'd0);
      send_item(cvs_pkg::OP_START, 12'h123, 12'h456);
      run_sweep(16, 1'b0);
      drain_results();
   endtask

   // Begin above the first vertex clamps straight onto it; a start mid-sweep restarts.
   task automatic test_wrong_side_restart();
      csr_write(cvs_pkg::REG_BEGIN_VOLTAGE, 16'd100);
      csr_write(cvs_pkg::REG_FIRST_VERTEX, 16'd50);
      csr_write(cvs_pkg::REG_STEP_SIZE, 16'd7);
      csr_write(cvs_pkg::REG_CYCLE_COUNT, 16'd2);
      csr_write(cvs_pkg::REG_SAMPLE_PERIOD_MS, 16'd3);
      send_item(cvs_pkg::OP_START, 12'h001, 12'h002);
      run_sweep(2, 1'b0);
      send_item(cvs_pkg::OP_START, 12'h003, 12'h004);
      run_sweep(1, 1'b0);
      drain_results();
   endtask

   // Random sweeps: fresh registers, a start, ticks to the end, with restarts,
   // live register changes and stray ticks mixed in.
   task automatic test_random_sweeps();
      int step;
      int stride;
      int origin;
      int v1;
      int v2;
      logic [15:0] cycles;
      logic [15:0] period;
      while (items_sent < ITEM_TARGET) begin
         if (items_sent + QUIET_TAIL >= ITEM_TARGET)
            quiet_tail = 1'b1;
         drain_results();

         case ($urandom_range(0, 15))
            0:       step = 0;
            1:       step = 32767;
            2:       step = $urandom_range(1, 32767);
            default: step = $urandom_range(1, 9);
         endcase
         stride = (step == 0) ? 1 : step;
         origin = int'($urandom_range(0, 65535)) - 32768;
         if ($urandom_range(0, 7) == 0) begin
            v1 = int'($urandom_range(0, 65535)) - 32768;
            v2 = int'($urandom_range(0, 65535)) - 32768;
         end else begin
            v1 = int'(clamp16(origin + int'($urandom_range(0, 6)) * stride
                              - int'($urandom_range(0, 3))));
            v1 = int'($signed(v1[15:0]));
            v2 = int'(clamp16(v1 - int'($urandom_range(0, 6)) * stride
                              - int'($urandom_range(0, 3))));
         end
         case ($urandom_range(0, 11))
            0:       cycles = 16'd0;
            1:       cycles = 16'd255;
            2:       cycles = 16'($urandom_range(0, 255));
            default: cycles = 16'($urandom_range(1, 3));
         endcase
         case ($urandom_range(0, 7))
            0:       period = 16'd0;
            1:       period = 16'hFFFF;
            default: period = 16'($urandom);
         endcase

         csr_write(cvs_pkg::REG_BEGIN_VOLTAGE, 16'(origin));
         csr_write(cvs_pkg::REG_FIRST_VERTEX, clamp16(v1));
         csr_write(cvs_pkg::REG_SECOND_VERTEX, 16'(v2));
         csr_write(cvs_pkg::REG_STEP_SIZE, 16'(step));
         csr_write(cvs_pkg::REG_CYCLE_COUNT, cycles);
         csr_write(cvs_pkg::REG_SAMPLE_PERIOD_MS, period);
         send_item(cvs_pkg::OP_START, 12'($urandom_range(0, 4095)),
                   12'($urandom_range(0, 4095)));

         case ($urandom_range(0, 9))
            0: begin
               // Restart while the sweep is still running.
               run_sweep($urandom_range(1, 6), 1'b0);
               send_item(cvs_pkg::OP_START, 12'($urandom_range(0, 4095)),
                         12'($urandom_range(0, 4095)));
               run_sweep(SWEEP_TICKS, 1'b0);
            end
            1: begin
               // Register change part-way through; cycle count must not matter here.
               run_sweep($urandom_range(1, 8), 1'b0);
               drain_results();
               csr_write(cvs_pkg::reg_index_type'($urandom_range(0, 5)), 16'($urandom));
               run_sweep(SWEEP_TICKS, 1'b0);
            end
            default: run_sweep(SWEEP_TICKS, 1'b0);
         endcase

         // Stray ticks once the sweep has finished are ignored.
         repeat ($urandom_range(0, 2))
            send_item(cvs_pkg::OP_TICK, 12'($urandom_range(0, 4095)),
                      12'($urandom_range(0, 4095)));
      end
   endtask

   initial begin
      reset                = 1'b1;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      req_bus.valid        = 1'b0;
      req_bus.operation    = cvs_pkg::OP_START;
      req_bus.voltage_code = '0;
      req_bus.current_code = '0;
      rsp_bus.ready        = 1'b1;
      clock_cycles         = 0;
      items_sent           = 0;
      mismatch_count       = 0;
      stall_left           = 0;
      flow_left            = 0;
      quiet_tail           = 1'b0;

      // Register and sweep state after reset.
      sweep_cfg.begin_voltage    = '0;
      sweep_cfg.first_vertex     = '0;
      sweep_cfg.second_vertex    = '0;
      sweep_cfg.step_size        = 15'd1;
      sweep_cfg.cycle_count      = 8'd1;
      sweep_cfg.sample_period_ms = 16'd1;
      model_setpoint             = '0;
      model_segment              = cvs_pkg::SEG_RISE_V1;
      model_cycles_left          = '0;
      model_points               = '0;
      model_time                 = '0;
      model_running              = 1'b0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_idle_ticks();
      test_full_scale_sweep();
      test_zero_step_and_period();
      test_wrong_side_restart();
      test_random_sweeps();

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_points.size() == 0)
         $display("cyclic_voltammetry_sweep: match");
      else
         $display("cyclic_voltammetry_sweep: mismatch");
      $finish;
   end

endmodule
